// ----- rtl/utf8_stream_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared property forms for the checker of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define UTF8SD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define UTF8SD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define UTF8SD_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/utf8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types, constants and lead byte classification shared by the decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

   localparam int UTF8SD_JOB_DEPTH = 2;
   localparam int UTF8SD_RSP_DEPTH = 2;

   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;
   localparam logic [7:0] LEAD2_BITS = 8'h1F;
   localparam logic [7:0] LEAD3_BITS = 8'h0F;
   localparam logic [7:0] LEAD4_BITS = 8'h07;

   // Work handed from the front to the back: raw bytes first, then an
   // optional decoded (or plain ASCII) result.
   typedef struct packed {
      logic [3:0][7:0] raw_bytes;
      logic [2:0]      raw_count;
      logic            final_valid;
      logic [20:0]     final_cp;
      logic [2:0]      final_used;
   } job_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic        raw_fallback;
      logic [2:0]  bytes_used;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        bad;
      logic [1:0]  extra;
      logic [20:0] bits;
   } lead_class_type;

   function automatic lead_class_type classify_lead(input logic [7:0] b);
      lead_class_type lc;
      lc.bad   = 1'b0;
      lc.extra = 2'd0;
      lc.bits  = {13'd0, b};
      if ((b & ASCII_MASK) == 8'h00) begin
         lc.extra = 2'd0;
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
         lc.extra = 2'd1;
         lc.bits  = {13'd0, b & LEAD2_BITS};
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
         lc.extra = 2'd2;
         lc.bits  = {13'd0, b & LEAD3_BITS};
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
         lc.extra = 2'd3;
         lc.bits  = {13'd0, b & LEAD4_BITS};
      end else begin
         lc.bad = 1'b1;
      end
      return lc;
   endfunction

endpackage

// ----- rtl/utf8_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder
// Byte-in, code-point-out decoder with raw fallback on broken sequences.
// ----------------------------------------------------------------------------
// A text enters one byte per transfer, with req_end_of_text marking its last
// byte; decoded code points leave through a queue-style result port. Well
// formed text sustains one byte per cycle while results are popped: the
// front end classifies each byte as it is accepted and the back end emits one
// result per cycle while the result queue has room. A byte that breaks a
// sequence, or a text that ends inside one, makes the block hand out the held
// lead and every byte after it as raw one-byte results, so one byte can cause
// up to four results, and the job queue lets the front keep taking bytes
// meanwhile. Work passes the job queue and then the result queue on its way
// to the rsp_ ports. Bytes that only extend an open sequence cause no
// result. rsp_last_of_run marks the final result caused by a byte.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import utf8sd_pkg::*; #(
   parameter int JOB_DEPTH = UTF8SD_JOB_DEPTH,
   parameter int RSP_DEPTH = UTF8SD_RSP_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   // result output
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [20:0] rsp_code_point,
   output logic        rsp_raw_fallback,
   output logic [2:0]  rsp_bytes_used,
   output logic        rsp_last_of_run
);

   job_type job_wr, job_rd;
   rsp_type rsp_wr, rsp_rd;
   logic    job_push, job_full, job_pop, job_empty;
   logic    rsp_push, rsp_full;

   // Hold back input only when the job queue has no room.
   assign req_full = job_full;

   utf8sd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .job_full        (job_full),
      .job_push        (job_push),
      .job             (job_wr)
   );

   // Decouple classification from result emission.
   utf8sd_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rd),
      .empty     (job_empty)
   );

   utf8sd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_rd),
      .job_pop   (job_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr)
   );

   // Result queue: the oldest waiting result sits at its head.
   utf8sd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_rd),
      .empty     (rsp_empty)
   );

   assign rsp_code_point   = rsp_rd.code_point;
   assign rsp_raw_fallback = rsp_rd.raw_fallback;
   assign rsp_bytes_used   = rsp_rd.bytes_used;
   assign rsp_last_of_run  = rsp_rd.last_of_run;

endmodule

// ----- rtl/utf8sd_fifo.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder queue
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module utf8sd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/utf8sd_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts text bytes, tracks the open sequence and issues jobs to the back.
// ----------------------------------------------------------------------------
module utf8sd_front import utf8sd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_text,
   input  logic       job_full,
   output logic       job_push,
   output job_type    job
);

   logic [1:0]  expected_ff, expected_in;
   logic [1:0]  seen_ff, seen_in;
   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  tail_ff [2];
   logic [7:0]  tail_in [2];
   logic [20:0] partial_ff, partial_in;

   logic           accept;
   logic           is_open;
   logic           is_cont;
   logic [2:0]     base_count;
   lead_class_type lead_info;

   always_comb begin
      accept     = req_push && !job_full;
      is_open    = (expected_ff != 2'd0);
      is_cont    = ((req_data_byte & CONT_MASK) == CONT_TAG);
      lead_info  = classify_lead(req_data_byte);
      base_count = is_open ? ({1'b0, seen_ff} + 3'd1) : 3'd0;

      expected_in = expected_ff;
      seen_in     = seen_ff;
      lead_in     = lead_ff;
      tail_in     = tail_ff;
      partial_in  = partial_ff;

      job.raw_bytes[0] = lead_ff;
      job.raw_bytes[1] = tail_ff[0];
      job.raw_bytes[2] = tail_ff[1];
      job.raw_bytes[3] = 8'h00;
      job.raw_bytes[base_count[1:0]] = req_data_byte;
      job.raw_count   = base_count;
      job.final_valid = 1'b0;
      job.final_cp    = {13'd0, req_data_byte};
      job.final_used  = 3'd1;
      job_push        = 1'b0;

      if (accept) begin
         if (is_open && is_cont) begin
            if (seen_ff + 2'd1 == expected_ff) begin
               // sequence complete
               job.raw_count   = 3'd0;
               job.final_valid = 1'b1;
               job.final_cp    = {partial_ff[14:0], req_data_byte[5:0]};
               job.final_used  = {1'b0, expected_ff} + 3'd1;
               job_push        = 1'b1;
               expected_in     = 2'd0;
               seen_in         = 2'd0;
            end else if (!req_end_of_text) begin
               // extend and keep waiting
               seen_in             = seen_ff + 2'd1;
               tail_in[seen_ff[0]] = req_data_byte;
               partial_in          = {partial_ff[14:0], req_data_byte[5:0]};
            end else begin
               // cut off: every held byte and this one go out raw
               job.raw_count = base_count + 3'd1;
               job_push      = 1'b1;
               expected_in   = 2'd0;
               seen_in       = 2'd0;
            end
         end else begin
            // any held bytes go out raw, then this byte starts afresh
            expected_in = 2'd0;
            seen_in     = 2'd0;
            if (lead_info.bad) begin
               job.raw_count = base_count + 3'd1;
               job_push      = 1'b1;
            end else if (lead_info.extra == 2'd0) begin
               job.final_valid = 1'b1;
               job_push        = 1'b1;
            end else if (!req_end_of_text) begin
               expected_in = lead_info.extra;
               lead_in     = req_data_byte;
               partial_in  = lead_info.bits;
               job_push    = (base_count != 3'd0);
            end else begin
               job.raw_count = base_count + 3'd1;
               job_push      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 2'd0;
         seen_ff     <= 2'd0;
      end else begin
         expected_ff <= expected_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      lead_ff    <= lead_in;
      tail_ff    <= tail_in;
      partial_ff <= partial_in;
   end

endmodule

// ----- rtl/utf8sd_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Walks one job per pass, emitting one result per cycle while rsp_full is low.
// ----------------------------------------------------------------------------
module utf8sd_back import utf8sd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job,
   output logic    job_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   logic [1:0] idx_ff, idx_in;
   logic [2:0] total;
   logic       is_raw;
   logic       is_last;

   always_comb begin
      total   = job.raw_count + {2'd0, job.final_valid};
      is_raw  = ({1'b0, idx_ff} < job.raw_count);
      is_last = (({1'b0, idx_ff} + 3'd1) == total);

      if (is_raw) begin
         rsp.code_point   = {13'd0, job.raw_bytes[idx_ff]};
         rsp.raw_fallback = 1'b1;
         rsp.bytes_used   = 3'd1;
      end else begin
         rsp.code_point   = job.final_cp;
         rsp.raw_fallback = 1'b0;
         rsp.bytes_used   = job.final_used;
      end
      rsp.last_of_run = is_last;

      rsp_push = !job_empty && !rsp_full;
      job_pop  = rsp_push && is_last;

      idx_in = idx_ff;
      if (rsp_push) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- rtl/utf8sd_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level properties of the decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_defines.svh"

module utf8sd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [20:0] rsp_code_point,
   input logic        rsp_raw_fallback,
   input logic [2:0]  rsp_bytes_used,
   input logic        rsp_last_of_run
);

   `UTF8SD_ASSERT_NOW(a_used_range, !rsp_empty,
      (rsp_bytes_used != 3'd0 && rsp_bytes_used <= 3'd4), "bytes_used out of range")
   `UTF8SD_ASSERT_NOW(a_raw_is_byte, !rsp_empty && rsp_raw_fallback,
      (rsp_bytes_used == 3'd1 && rsp_code_point < 21'd256), "raw result is not a single byte")
   `UTF8SD_ASSERT_NOW(a_single_is_ascii,
      !rsp_empty && !rsp_raw_fallback && rsp_bytes_used == 3'd1,
      rsp_code_point < 21'd128, "one-byte decode above ASCII")
   `UTF8SD_ASSERT_NEXT(a_head_holds, !rsp_empty && !rsp_pop,
      (!rsp_empty && $stable(rsp_code_point) && $stable(rsp_last_of_run)),
      "result changed while stalled")
   `UTF8SD_ASSERT_RESET(a_reset_empty, reset, (rsp_empty && !req_full),
      "queues not clear after reset")

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (.*);
